// File: rtl/aprb_pkg.sv
// ----------------------------------------------------------------------------
// aprb_pkg
// Shared types and constants for the aging point ring buffer.
// ----------------------------------------------------------------------------
package aprb_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIFE_W = 16;
  localparam int IN_W = 136;
  localparam int OUT_W = 136;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_EXPIRE = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0]       x;
    logic [31:0]       y;
    logic [LIFE_W-1:0] life;
    logic [14:0]       half;
    logic [31:0]       color;
  } entry_t;

  typedef struct packed {
    logic              shift;
    logic              dec;
    logic [LIFE_W-1:0] delta;
  } cell_ctrl_t;

endpackage

// File: rtl/aprb_cell.sv
// ----------------------------------------------------------------------------
// aprb_cell
// One point slot: load, shift from neighbor, or age by delta.
// ----------------------------------------------------------------------------
module aprb_cell (
  input  logic                clk,
  input  aprb_pkg::cell_ctrl_t ctrl,
  input  logic                wr_en,
  input  aprb_pkg::entry_t    wr_data,
  input  aprb_pkg::entry_t    nb_data,
  output aprb_pkg::entry_t    data
);
  import aprb_pkg::*;

  entry_t data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (wr_en) begin
      data_nxt = wr_data;
    end else if (ctrl.shift) begin
      data_nxt = nb_data;
    end else if (ctrl.dec) begin
      data_nxt.life = (data_r.life > ctrl.delta) ? data_r.life - ctrl.delta : '0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: rtl/aging_point_ring_buffer.sv
// ----------------------------------------------------------------------------
// aging_point_ring_buffer
// Trail point buffer built as a row of cells ordered oldest first.
// ----------------------------------------------------------------------------
// Add, clear and read register their result when they are taken. A tick
// ages every cell, then removes expired points from the front, the row
// shifting by one cell per cycle, and then finishes. One item is in work
// at a time; while a result waits in the result register the input is held
// off, and the next item is taken at the earliest in the cycle that result
// transfers.
module aging_point_ring_buffer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,   // base_life
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], thickness[79:64], color_r[87:80], color_g[95:88],
  // color_b[103:96], color_a[111:104], delta_time[127:112], read_index[133:128]
  input  logic [aprb_pkg::IN_W-1:0]  in_tdata,
  input  logic [1:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_count[6:0], out_pos_x[38:7], out_pos_y[70:39], out_life[86:71],
  // out_half_thickness[101:87], out_color[133:102]
  output logic [aprb_pkg::OUT_W-1:0] out_tdata,
  output logic         out_tuser   // read_valid
);
  import aprb_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       base_life_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_rv_r, out_rv_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  entry_t     cells [DEPTH];
  entry_t     new_e, newest, rd_e;
  cell_ctrl_t ctrl;
  logic [DEPTH-1:0] wr_en;
  logic       xfer, match, full;
  mode_t      mode;
  logic [IDX_W-1:0] ridx, last_idx;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign xfer = in_tvalid && in_tready;
  assign mode = mode_t'(in_tuser);
  assign ridx = in_tdata[133:128];
  assign full = (count_r == CNT_W'(DEPTH));
  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    new_e.x = in_tdata[31:0];
    new_e.y = in_tdata[63:32];
    new_e.life = base_life_r;
    new_e.half = in_tdata[79:65];
    new_e.color = {in_tdata[87:80], in_tdata[95:88], in_tdata[103:96], in_tdata[111:104]};
  end

  always_comb begin
    newest = '0;
    rd_e = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_idx == IDX_W'(i)) newest = newest | cells[i];
      if (ridx == IDX_W'(i)) rd_e = rd_e | cells[i];
    end
  end

  assign match = (count_r != '0) && (newest.x == new_e.x) && (newest.y == new_e.y);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      entry_t nb;
      if (g == DEPTH - 1) begin : g_last
        assign nb = new_e;
      end else begin : g_mid
        assign nb = cells[g+1];
      end
      aprb_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .wr_en   (wr_en[g]),
        .wr_data (new_e),
        .nb_data (nb),
        .data    (cells[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ctrl = '0;
    ctrl.delta = in_tdata[127:112];
    wr_en = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rv_nxt = out_rv_r;
    out_data_nxt = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (xfer) begin
          out_rv_nxt = 1'b0;
          out_data_nxt = '0;
          case (mode)
            MODE_ADD: begin
              if (match) begin
                wr_en[last_idx] = 1'b1;
              end else if (full) begin
                ctrl.shift = 1'b1;
              end else begin
                wr_en[count_r[IDX_W-1:0]] = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            MODE_TICK: begin
              ctrl.dec = 1'b1;
              state_nxt = ST_EXPIRE;
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
              if (CNT_W'(ridx) < count_r) begin
                out_rv_nxt = 1'b1;
                out_data_nxt[133:7] = {rd_e.color, rd_e.half, rd_e.life, rd_e.y, rd_e.x};
              end
            end
          endcase
          out_data_nxt[6:0] = count_nxt;
        end
      end
      default: begin
        if (count_r != '0 && cells[0].life == '0) begin
          ctrl.shift = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_rv_nxt = 1'b0;
          out_data_nxt = '0;
          out_data_nxt[6:0] = count_r;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      base_life_r <= 16'd1024;
      out_valid_r <= 1'b0;
      out_rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_rv_r <= out_rv_nxt;
      if (cfg_valid && cfg_ready) base_life_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_rv_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("count above depth");
  a_expire_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXPIRE |-> !in_tready && !out_valid_r) else $error("busy overlap");
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rv_r |-> out_data_r[6:0] != '0) else $error("read on empty");
  a_shift_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXPIRE && ctrl.shift |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("expire count");

endmodule
